// ===== sv/qwg_pkg.sv =====
// Shared types, constants and helper functions of the q-gram window generator.
package qwg_pkg;

  // Window and character geometry
  localparam int MAX_GRAM = 8;
  localparam int CHAR_W   = 8;
  localparam int WORD_W   = MAX_GRAM * CHAR_W;
  localparam int QLEN_W   = 4;
  localparam int CNT_W    = 4;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GRAM_LENGTH    = 3'd0,
    REG_PAD_ENABLE     = 3'd1,
    REG_DROP_SPACED    = 3'd2,
    REG_START_PAD_CHAR = 3'd3,
    REG_END_PAD_CHAR   = 3'd4
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [QLEN_W-1:0] GRAM_LENGTH_RST    = 4'd3;
  localparam logic              PAD_ENABLE_RST     = 1'b1;
  localparam logic              DROP_SPACED_RST    = 1'b0;
  localparam logic [CHAR_W-1:0] START_PAD_CHAR_RST = 8'd35;
  localparam logic [CHAR_W-1:0] END_PAD_CHAR_RST   = 8'd36;

  typedef struct packed {
    logic [QLEN_W-1:0] gram_length;
    logic              pad_enable;
    logic              drop_spaced;
    logic [CHAR_W-1:0] start_pad_char;
    logic [CHAR_W-1:0] end_pad_char;
  } cfg_t;

  // One classified character: its window and the steps that give a beat
  typedef struct packed {
    logic [WORD_W-1:0]   window;
    logic [MAX_GRAM-1:0] step_mask;
    logic                marker;
    logic                last;
  } cmd_t;

  // Clamp the programmed gram length to 1..MAX_GRAM.
  function automatic logic [QLEN_W-1:0] eff_q(logic [QLEN_W-1:0] len);
    logic [QLEN_W-1:0] q;
    q = len;
    if (len == '0) q = QLEN_W'(1);
    else if (len > QLEN_W'(MAX_GRAM)) q = QLEN_W'(MAX_GRAM);
    return q;
  endfunction

  // Byte mask that keeps the lowest q characters of a window.
  function automatic logic [WORD_W-1:0] gram_mask(logic [QLEN_W-1:0] q);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int j = 0; j < MAX_GRAM; j++) begin
      if (j < int'(q)) m[j*CHAR_W +: CHAR_W] = '1;
    end
    return m;
  endfunction

endpackage

// ===== sv/qgram_window_generator_core.sv =====
// Top level of the q-gram window generator: configuration registers, front, queue and back.
// A character passes a queue entry, the sequencer and the output register, in that order.
// Throughput: one character per cycle while each character gives at most one result beat
// and the output does not stall. A padded string's last character holds the back end for
// up to q steps, q = effective gram length; the two-entry queue absorbs two more characters.
// Reset (synchronous, active low) empties the queue and output and restores register defaults.
module qgram_window_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] char_in
  input  logic                              in_tlast,   // is_last_char
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qwg_pkg::WORD_W-1:0]        out_tdata,  // [63:0] gram_word
  output logic [0:0]                        out_tuser,  // [0] gram_present
  output logic                              out_tlast,  // string_end
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [qwg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [qwg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [qwg_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  qwg_pkg::cfg_t     cfg_r;
  qwg_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  logic              q_push;
  logic              q_ready;
  logic              q_pop;
  logic              q_valid;
  qwg_pkg::cmd_t     push_cmd;
  qwg_pkg::cmd_t     pop_cmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = qwg_pkg::reg_idx_t'(cfg_paddr[qwg_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gram_length    <= qwg_pkg::GRAM_LENGTH_RST;
      cfg_r.pad_enable     <= qwg_pkg::PAD_ENABLE_RST;
      cfg_r.drop_spaced    <= qwg_pkg::DROP_SPACED_RST;
      cfg_r.start_pad_char <= qwg_pkg::START_PAD_CHAR_RST;
      cfg_r.end_pad_char   <= qwg_pkg::END_PAD_CHAR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        qwg_pkg::REG_GRAM_LENGTH:    cfg_r.gram_length    <= cfg_pwdata[qwg_pkg::QLEN_W-1:0];
        qwg_pkg::REG_PAD_ENABLE:     cfg_r.pad_enable     <= cfg_pwdata[0];
        qwg_pkg::REG_DROP_SPACED:    cfg_r.drop_spaced    <= cfg_pwdata[0];
        qwg_pkg::REG_START_PAD_CHAR: cfg_r.start_pad_char <= cfg_pwdata[qwg_pkg::CHAR_W-1:0];
        qwg_pkg::REG_END_PAD_CHAR:   cfg_r.end_pad_char   <= cfg_pwdata[qwg_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      qwg_pkg::REG_GRAM_LENGTH:    cfg_prdata = qwg_pkg::CFG_DATA_W'(cfg_r.gram_length);
      qwg_pkg::REG_PAD_ENABLE:     cfg_prdata = qwg_pkg::CFG_DATA_W'(cfg_r.pad_enable);
      qwg_pkg::REG_DROP_SPACED:    cfg_prdata = qwg_pkg::CFG_DATA_W'(cfg_r.drop_spaced);
      qwg_pkg::REG_START_PAD_CHAR: cfg_prdata = qwg_pkg::CFG_DATA_W'(cfg_r.start_pad_char);
      qwg_pkg::REG_END_PAD_CHAR:   cfg_prdata = qwg_pkg::CFG_DATA_W'(cfg_r.end_pad_char);
      default:                     cfg_prdata = '0;
    endcase
  end

  qwg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  qwg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  qwg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/qwg_front.sv =====
// Front end: accepts characters, keeps the window and classifies which grams survive.
module qwg_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  qwg_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [qwg_pkg::CHAR_W-1:0]            in_char,
  input  logic                                  in_last,
  input  logic                                  q_ready,
  output logic                                  q_push,
  output qwg_pkg::cmd_t                         q_cmd
);

  logic [qwg_pkg::WORD_W-1:0]   win_r;
  logic [qwg_pkg::CNT_W-1:0]    cs_r;
  logic                         in_string_r;

  logic                         accept;
  logic [qwg_pkg::QLEN_W-1:0]   q;
  logic [2:0]                   qm1;
  logic [qwg_pkg::WORD_W-1:0]   win_pre;
  logic [qwg_pkg::WORD_W-1:0]   win_nxt;
  logic [qwg_pkg::CNT_W-1:0]    cs_pre;
  logic [qwg_pkg::CNT_W-1:0]    cs_nxt;
  logic [qwg_pkg::MAX_GRAM-1:0] sp;
  logic [qwg_pkg::MAX_GRAM-1:0] has_sp;
  logic [qwg_pkg::MAX_GRAM-1:0] mask;
  logic                         end_sp;

  assign accept   = in_valid && q_ready;
  assign in_ready = q_ready;

  // Start padding and the shift of the new character into the window.
  always_comb begin
    q       = qwg_pkg::eff_q(cfg.gram_length);
    qm1     = 3'(q - qwg_pkg::QLEN_W'(1));
    win_pre = win_r;
    cs_pre  = cs_r;
    if (!in_string_r) begin
      cs_pre = '0;
      if (cfg.pad_enable) begin
        win_pre = win_r << {qm1, 3'b000};
        for (int j = 0; j < qwg_pkg::MAX_GRAM; j++) begin
          if (j < int'(qm1)) win_pre[j*qwg_pkg::CHAR_W +: qwg_pkg::CHAR_W] = cfg.start_pad_char;
        end
        cs_pre = {1'b0, qm1};
      end
    end
    cs_nxt  = (cs_pre >= qwg_pkg::CNT_W'(qwg_pkg::MAX_GRAM)) ?
              qwg_pkg::CNT_W'(qwg_pkg::MAX_GRAM) : cs_pre + qwg_pkg::CNT_W'(1);
    win_nxt = {win_pre[qwg_pkg::WORD_W-qwg_pkg::CHAR_W-1:0], in_char};
  end

  // Classify each step: step 0 is the new window, later steps shift in end pads.
  always_comb begin
    end_sp = (cfg.end_pad_char == qwg_pkg::SPACE_CHAR);
    for (int j = 0; j < qwg_pkg::MAX_GRAM; j++) begin
      sp[j] = (win_nxt[j*qwg_pkg::CHAR_W +: qwg_pkg::CHAR_W] == qwg_pkg::SPACE_CHAR);
    end
    for (int k = 0; k < qwg_pkg::MAX_GRAM; k++) begin
      has_sp[k] = (k > 0) && end_sp;
      for (int j = 0; j < qwg_pkg::MAX_GRAM; j++) begin
        if ((j + k < int'(q)) && sp[j]) has_sp[k] = 1'b1;
      end
      mask[k] = ((k == 0) || (in_last && cfg.pad_enable && (k < int'(q)))) &&
                ((int'(cs_nxt) + k) >= int'(q)) &&
                !(cfg.drop_spaced && has_sp[k]);
    end
  end

  // A character enters the queue only if it yields a beat or ends a string.
  always_comb begin
    q_push           = accept && ((mask != '0) || in_last);
    q_cmd.window     = win_nxt;
    q_cmd.marker     = (mask == '0);
    q_cmd.step_mask  = (mask == '0) ? qwg_pkg::MAX_GRAM'(1) : mask;
    q_cmd.last       = in_last;
  end

  // String tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r <= 1'b0;
      cs_r        <= '0;
    end else if (accept) begin
      in_string_r <= !in_last;
      cs_r        <= cs_nxt;
    end
  end

  // Window contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== sv/qwg_queue.sv =====
// Short command queue that decouples the front end from the gram sequencer.
module qwg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qwg_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output qwg_pkg::cmd_t pop_cmd
);

  qwg_pkg::cmd_t                mem_r [qwg_pkg::QDEPTH];
  logic [qwg_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [qwg_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [qwg_pkg::QPTR_W:0]     count_r;

  assign ready   = (count_r != (qwg_pkg::QPTR_W+1)'(qwg_pkg::QDEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + qwg_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + qwg_pkg::QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + (qwg_pkg::QPTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (qwg_pkg::QPTR_W+1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/qwg_back.sv =====
// Back end: walks the steps of each command and drives the result beats.
module qwg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qwg_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  qwg_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [qwg_pkg::WORD_W-1:0]    out_tdata,
  output logic [0:0]                    out_tuser,
  output logic                          out_tlast
);

  logic                         active_r;
  logic [qwg_pkg::WORD_W-1:0]   win_r;
  logic [qwg_pkg::MAX_GRAM-1:0] mask_r;
  logic                         marker_r;
  logic                         last_r;

  logic                         out_valid_r;
  logic [qwg_pkg::WORD_W-1:0]   out_word_r;
  logic                         out_present_r;
  logic                         out_end_r;

  logic                         slot_free;
  logic                         step;
  logic                         emit;
  logic                         rest_empty;
  logic                         done;
  logic                         load;

  // Sequencer control: a step without a beat never waits on the output.
  always_comb begin
    slot_free  = !out_valid_r || out_tready;
    step       = active_r && (!mask_r[0] || slot_free);
    emit       = active_r && mask_r[0] && slot_free;
    rest_empty = (mask_r[qwg_pkg::MAX_GRAM-1:1] == '0);
    done       = step && rest_empty;
    load       = (!active_r || done) && q_valid;
    q_pop      = load;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (done) begin
      active_r <= 1'b0;
    end
  end

  // Current command, shifted one end pad per step.
  always_ff @(posedge clk) begin
    if (load) begin
      win_r    <= q_cmd.window;
      mask_r   <= q_cmd.step_mask;
      marker_r <= q_cmd.marker;
      last_r   <= q_cmd.last;
    end else if (step) begin
      win_r  <= {win_r[qwg_pkg::WORD_W-qwg_pkg::CHAR_W-1:0], cfg.end_pad_char};
      mask_r <= mask_r >> 1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r    <= marker_r ? '0 :
                       (win_r & qwg_pkg::gram_mask(qwg_pkg::eff_q(cfg.gram_length)));
      out_present_r <= !marker_r;
      out_end_r     <= last_r && rest_empty;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_word_r;
  assign out_tuser[0] = out_present_r;
  assign out_tlast    = out_end_r;

endmodule

// ===== sv/qwg_checker.sv =====
// Port-level checker for the q-gram window generator, bound to the top level.
module qwg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [qwg_pkg::WORD_W-1:0]     out_tdata,
  input logic [0:0]                     out_tuser,
  input logic                           out_tlast
);

  logic [3:0] pend_r;
  logic       in_end;
  logic       out_end;

  assign in_end  = in_tvalid && in_tready && in_tlast;
  assign out_end = out_tvalid && out_tready && out_tlast;

  // Strings whose last character went in but whose final beat has not gone out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_end) - 4'(out_end);
    end
  end

  // A string-end beat needs a string that has actually ended on the input.
  a_end_has_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> pend_r != '0)
    else $error("string end beat without a finished input string");

  // An end marker carries no gram and always closes its string.
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("end marker beat is malformed");

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat visible right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

endmodule

bind qgram_window_generator_core qwg_checker u_qwg_checker (.*);

// ===== dv/qgram_window_generator_checker.sv =====
// Checker of the q-gram window generator: watches the channels, predicts grams and compares.
`timescale 1ns / 1ps

module qgram_window_generator_checker
  import qwg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_in
  input  logic                  in_tlast,   // is_last_char
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [WORD_W-1:0]     out_tdata,  // [63:0] gram_word
  input  logic [0:0]            out_tuser,  // [0] gram_present
  input  logic                  out_tlast,  // string_end
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int unsigned           fail_count,
  output int unsigned           gram_backlog
);

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              present;
    logic              str_end;
  } gram_beat_t;

  gram_beat_t        expected_grams[$];
  cfg_t              regs;
  logic [CHAR_W-1:0] window[MAX_GRAM];
  int unsigned       valid_chars;
  logic              mid_string;
  int unsigned       errors = 0;

  // Programmed length limited to 1..MAX_GRAM.
  function automatic int unsigned window_length(logic [QLEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_GRAM) return MAX_GRAM;
    return len;
  endfunction

  task automatic push_char(logic [CHAR_W-1:0] c);
    for (int i = 0; i < MAX_GRAM - 1; i++) window[i] = window[i + 1];
    window[MAX_GRAM - 1] = c;
    if (valid_chars < MAX_GRAM) valid_chars++;
  endtask

  // Queue the current gram if the window is full enough and it is not dropped.
  task automatic take_gram(int unsigned q, inout int unsigned n);
    gram_beat_t beat;
    logic       spaced;
    beat.word = '0;
    spaced    = 1'b0;
    if (valid_chars < q) return;
    for (int i = MAX_GRAM - q; i < MAX_GRAM; i++) begin
      beat.word = (beat.word << CHAR_W) | WORD_W'(window[i]);
      if (window[i] == SPACE_CHAR) spaced = 1'b1;
    end
    if (regs.drop_spaced && spaced) return;
    beat.present = 1'b1;
    beat.str_end = 1'b0;
    expected_grams = {expected_grams, beat};
    n++;
  endtask

  // Work out every gram one accepted character gives.
  task automatic predict_grams(logic [CHAR_W-1:0] c, logic last);
    int unsigned q;
    int unsigned n;
    gram_beat_t  beat;
    q = window_length(regs.gram_length);
    n = 0;
    if (!mid_string) begin
      valid_chars = 0;
      if (regs.pad_enable) begin
        for (int k = 1; k < q; k++) push_char(regs.start_pad_char);
      end
      mid_string = 1'b1;
    end
    push_char(c);
    take_gram(q, n);
    if (last) begin
      if (regs.pad_enable) begin
        for (int k = 1; k < q; k++) begin
          push_char(regs.end_pad_char);
          take_gram(q, n);
        end
      end
      // With no gram left, a marker beat closes the string.
      if (n == 0) begin
        beat.word    = '0;
        beat.present = 1'b0;
        beat.str_end = 1'b1;
        expected_grams = {expected_grams, beat};
      end else begin
        expected_grams[expected_grams.size() - 1].str_end = 1'b1;
      end
      mid_string = 1'b0;
    end
  endtask

  task automatic check_beat();
    gram_beat_t want;
    if (expected_grams.size() == 0) begin
      $error("result beat with no gram expected: gram_word %h", out_tdata);
      errors++;
      return;
    end
    want = expected_grams.pop_front();
    if (out_tdata !== want.word) begin
      $error("gram_word expected %h actual %h", want.word, out_tdata);
      errors++;
    end
    if (out_tuser[0] !== want.present) begin
      $error("gram_present expected %b actual %b", want.present, out_tuser[0]);
      errors++;
    end
    if (out_tlast !== want.str_end) begin
      $error("string_end expected %b actual %b", want.str_end, out_tlast);
      errors++;
    end
  endtask

  // Track registers, check result beats, then predict from input beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.gram_length    = GRAM_LENGTH_RST;
      regs.pad_enable     = PAD_ENABLE_RST;
      regs.drop_spaced    = DROP_SPACED_RST;
      regs.start_pad_char = START_PAD_CHAR_RST;
      regs.end_pad_char   = END_PAD_CHAR_RST;
      for (int i = 0; i < MAX_GRAM; i++) window[i] = '0;
      valid_chars = 0;
      mid_string  = 1'b0;
      expected_grams.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_GRAM_LENGTH:    regs.gram_length    = cfg_pwdata[QLEN_W-1:0];
          REG_PAD_ENABLE:     regs.pad_enable     = cfg_pwdata[0];
          REG_DROP_SPACED:    regs.drop_spaced    = cfg_pwdata[0];
          REG_START_PAD_CHAR: regs.start_pad_char = cfg_pwdata[CHAR_W-1:0];
          REG_END_PAD_CHAR:   regs.end_pad_char   = cfg_pwdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) predict_grams(in_tdata, in_tlast);
    end
    fail_count   <= errors;
    gram_backlog <= expected_grams.size();
  end

endmodule

// ===== dv/qgram_window_generator_core_test.sv =====
// Testbench top of the q-gram window generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module qgram_window_generator_core_test;
  import qwg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_CHARS  = 32;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [WORD_W-1:0]     out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned fail_count;
  int unsigned gram_backlog;
  int unsigned cycle_count = 0;
  logic        no_idle = 1'b0;

  qgram_window_generator_core i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  qgram_window_generator_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .gram_backlog
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("qgram_window_generator_core_test failed");
    $finish;
  end

  // Result side: a random stall before each beat.
  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // One input beat after a random gap.
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold off input until every expected gram has come and the block has gone quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gram_backlog != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [3:0] q, logic pad, logic drop, logic [7:0] sp,
                                logic [7:0] ep);
    wait_idle();
    cfg_write(REG_GRAM_LENGTH, CFG_DATA_W'(q));
    cfg_write(REG_PAD_ENABLE, CFG_DATA_W'(pad));
    cfg_write(REG_DROP_SPACED, CFG_DATA_W'(drop));
    cfg_write(REG_START_PAD_CHAR, CFG_DATA_W'(sp));
    cfg_write(REG_END_PAD_CHAR, CFG_DATA_W'(ep));
  endtask

  initial begin
    logic [3:0]  q;
    logic        pad;
    logic        drop;
    logic [7:0]  sp;
    logic [7:0]  ep;
    logic [7:0]  c;
    int unsigned q_eff;
    int unsigned len;
    int unsigned sent;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Reset settings: extreme bytes and a single-character string.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b1);
    send_text("q");

    // Spaces as start padding with dropping on: the first string keeps only its gram without spaces.
    apply_settings(4'd3, 1'b1, 1'b1, SPACE_CHAR, 8'd36);
    send_text("a");
    send_text("abc");

    // No padding: a string shorter than the gram gives only a marker.
    apply_settings(4'd4, 1'b0, 1'b0, 8'd35, 8'd36);
    send_text("ab");
    send_text("abcdef");

    // Longest gram with extreme pad characters.
    apply_settings(4'd8, 1'b1, 1'b0, 8'h00, 8'hFF);
    send_text("xyz");

    // Zero length acts as one; a lone space is dropped.
    apply_settings(4'd0, 1'b1, 1'b1, 8'hFF, 8'h00);
    send_text(" ");
    send_text("a b");

    // Length above the maximum acts as the maximum.
    apply_settings(4'd15, 1'b0, 1'b1, 8'd35, 8'd36);
    send_text("abcd efghi");

    // Random settings, each with a burst of random strings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       q = 4'd0;
        1:       q = 4'($urandom_range(9, 15));
        default: q = 4'($urandom_range(1, 8));
      endcase
      pad  = 1'($urandom_range(0, 1));
      drop = 1'($urandom_range(0, 1));
      sp   = ($urandom_range(0, 5) == 0) ? SPACE_CHAR : 8'($urandom_range(0, 255));
      ep   = ($urandom_range(0, 5) == 0) ? SPACE_CHAR : 8'($urandom_range(0, 255));
      apply_settings(q, pad, drop, sp, ep);
      no_idle = ($urandom_range(0, 3) == 0);
      q_eff = (q == 0) ? 1 : ((q > MAX_GRAM) ? MAX_GRAM : q);
      sent = 0;
      while (sent < PHASE_CHARS) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                          : $urandom_range(1, q_eff + 2);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0:       c = SPACE_CHAR;
            1:       c = sp;
            2:       c = ep;
            default: c = 8'($urandom_range(0, 255));
          endcase
          send_char(c, i == len - 1);
        end
        sent += len;
      end
      no_idle = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("qgram_window_generator_core_test passed");
    end else begin
      $display("qgram_window_generator_core_test failed");
    end
    $finish;
  end

endmodule
